// ===== rtl/xte_pkg.sv =====
`timescale 1ns / 1ps

package xte_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int RUN_W       = 3;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A_M10 = 8'h57;

    localparam logic [RUN_W-1:0] LEN_PASS     = 3'd1;
    localparam logic [RUN_W-1:0] LEN_HEX_ONE  = 3'd5;
    localparam logic [RUN_W-1:0] LEN_HEX_TWO  = 3'd6;
    localparam logic [RUN_W-1:0] LEN_QUOT     = 3'd6;
    localparam logic [RUN_W-1:0] LEN_AMP      = 3'd5;
    localparam logic [RUN_W-1:0] LEN_APOS     = 3'd6;
    localparam logic [RUN_W-1:0] LEN_LT       = 3'd4;
    localparam logic [RUN_W-1:0] LEN_GT       = 3'd4;

    localparam logic [0:5][7:0] ENT_QUOT_S = "&quot;";
    localparam logic [0:5][7:0] ENT_AMP_S  = {"&amp;", 8'h00};
    localparam logic [0:5][7:0] ENT_APOS_S = "&apos;";
    localparam logic [0:5][7:0] ENT_LT_S   = {"&lt;", 16'h0000};
    localparam logic [0:5][7:0] ENT_GT_S   = {"&gt;", 16'h0000};

    typedef enum logic [1:0] {
        KIND_PASS = 2'd0,
        KIND_ENT  = 2'd1,
        KIND_HEX  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ENT_QUOT = 3'd0,
        ENT_AMP  = 3'd1,
        ENT_APOS = 3'd2,
        ENT_LT   = 3'd3,
        ENT_GT   = 3'd4
    } t_ent;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       string_end;
    } t_out_beat;

    typedef struct packed {
        t_kind            kind;
        t_ent             ent;
        logic [7:0]       value;
        logic [RUN_W-1:0] len;
        logic             last;
    } t_desc;

    function automatic t_desc classify(input t_in_beat beat);
        t_desc d;
        d.kind  = KIND_PASS;
        d.ent   = ENT_QUOT;
        d.value = beat.in_char;
        d.len   = LEN_PASS;
        d.last  = beat.in_last;
        unique case (beat.in_char)
            CH_QUOT: begin
                d.kind = KIND_ENT;
                d.ent  = ENT_QUOT;
                d.len  = LEN_QUOT;
            end
            CH_AMP: begin
                d.kind = KIND_ENT;
                d.ent  = ENT_AMP;
                d.len  = LEN_AMP;
            end
            CH_APOS: begin
                d.kind = KIND_ENT;
                d.ent  = ENT_APOS;
                d.len  = LEN_APOS;
            end
            CH_LT: begin
                d.kind = KIND_ENT;
                d.ent  = ENT_LT;
                d.len  = LEN_LT;
            end
            CH_GT: begin
                d.kind = KIND_ENT;
                d.ent  = ENT_GT;
                d.len  = LEN_GT;
            end
            default: begin
                if (!(beat.in_char == CH_TAB || beat.in_char == CH_LF ||
                      (beat.in_char >= CH_SPACE && beat.in_char <= CH_TILDE))) begin
                    d.kind = KIND_HEX;
                    d.len  = (beat.in_char[7:4] != 4'h0) ? LEN_HEX_TWO : LEN_HEX_ONE;
                end
            end
        endcase
        return d;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        return (nib < 4'd10) ? (CH_ZERO + {4'h0, nib}) : (CH_A_M10 + {4'h0, nib});
    endfunction

    function automatic logic [7:0] ent_char(input t_ent ent, input logic [RUN_W-1:0] idx);
        logic [0:5][7:0] row;
        unique case (ent)
            ENT_QUOT: row = ENT_QUOT_S;
            ENT_AMP:  row = ENT_AMP_S;
            ENT_APOS: row = ENT_APOS_S;
            ENT_LT:   row = ENT_LT_S;
            ENT_GT:   row = ENT_GT_S;
            default:  row = ENT_QUOT_S;
        endcase
        return (idx > 3'd5) ? CH_SEMI : row[idx];
    endfunction

    function automatic logic [7:0] char_at(input t_desc d, input logic [RUN_W-1:0] idx);
        logic [7:0] c;
        c = d.value;
        unique case (d.kind)
            KIND_PASS: c = d.value;
            KIND_ENT:  c = ent_char(d.ent, idx);
            KIND_HEX: begin
                unique case (idx)
                    3'd0: c = CH_AMP;
                    3'd1: c = CH_HASH;
                    3'd2: c = CH_X;
                    3'd3: c = (d.len == LEN_HEX_TWO) ? hex_digit(d.value[7:4])
                                                     : hex_digit(d.value[3:0]);
                    3'd4: c = (d.len == LEN_HEX_TWO) ? hex_digit(d.value[3:0]) : CH_SEMI;
                    default: c = CH_SEMI;
                endcase
            end
            default: c = d.value;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/xte_front.sv =====
`timescale 1ns / 1ps

module xte_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  xte_pkg::t_in_beat i_data,
    input  logic              i_q_full,
    output logic              o_push,
    output xte_pkg::t_desc    o_desc
);

    logic           r_valid;
    xte_pkg::t_desc r_desc;
    logic           load;

    assign o_ready = !r_valid || !i_q_full;
    assign load    = i_valid && o_ready;
    assign o_push  = r_valid && !i_q_full;
    assign o_desc  = r_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_desc <= xte_pkg::classify(i_data);
        end
    end

endmodule

// ===== rtl/xte_queue.sv =====
`timescale 1ns / 1ps

module xte_queue #(
    parameter int DEPTH = xte_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  xte_pkg::t_desc i_desc,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_head_valid,
    output xte_pkg::t_desc o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    xte_pkg::t_desc   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

endmodule

// ===== rtl/xte_back.sv =====
`timescale 1ns / 1ps

module xte_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  xte_pkg::t_desc     i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output xte_pkg::t_out_beat o_data
);

    logic                      r_out_valid;
    xte_pkg::t_out_beat        r_out;
    logic [xte_pkg::RUN_W-1:0] r_idx;
    logic                      load;
    logic                      take;
    logic                      run_end;

    assign load    = !r_out_valid || i_ready;
    assign take    = load && i_head_valid;
    assign run_end = (r_idx == i_head.len - 1'b1);
    assign o_pop   = take && run_end;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (load) begin
                r_out_valid <= i_head_valid;
            end
            if (take) begin
                r_idx <= run_end ? '0 : r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.out_char   <= xte_pkg::char_at(i_head, r_idx);
            r_out.run_last   <= run_end;
            r_out.string_end <= run_end && i_head.last;
        end
    end

endmodule

// ===== rtl/xml_text_escaper_core.sv =====
`timescale 1ns / 1ps
// XML text escaper core.
// The input channel (i_valid, o_ready, i_data) takes one byte of a string per beat,
// with in_last marking the final byte. The output channel (o_valid, i_ready, o_data)
// gives one character of the escaped text per beat, with run_last on the last
// character produced for a byte and string_end on the last character of the string.
// A front stage registers and classifies each byte, a descriptor queue of
// QUEUE_DEPTH entries holds the classified bytes, and the back end emits one
// character per cycle from the queue head into an output register while the
// receiver takes them. A byte passes the front register, the queue and the output
// register in turn. Plain bytes flow at one per cycle unless the receiver stalls.
// An escaped byte gives four to six characters, set by its entity or character
// reference; the queue keeps taking bytes meanwhile until it and the front stage
// are full. When the receiver stalls, the output beat holds and the queue fills,
// and then o_ready falls. Reset empties every stage; nothing else is cleared.
module xml_text_escaper_core #(
    parameter int QUEUE_DEPTH = xte_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  xte_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output xte_pkg::t_out_beat o_data
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_head_valid;
    xte_pkg::t_desc q_in;
    xte_pkg::t_desc q_head;

    xte_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_desc   (q_in)
    );

    xte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_desc       (q_in),
        .o_full       (q_full),
        .i_pop        (q_pop),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    xte_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data       (o_data)
    );

endmodule

// ===== rtl/xte_checker.sv =====
`timescale 1ns / 1ps

module xte_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input xte_pkg::t_out_beat o_data
);

    // A stalled output beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output beat changed while stalled");

    // The string ends only on the last character of a byte.
    a_end_on_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.string_end |-> o_data.run_last)
        else $error("string_end without run_last");

    // An ampersand always opens an entity, so it never closes a run.
    a_amp_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.out_char == xte_pkg::CH_AMP) |-> !o_data.run_last)
        else $error("ampersand closed a run");

    // Markup characters never reach the output unescaped.
    a_no_markup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.out_char != xte_pkg::CH_LT) &&
                    (o_data.out_char != xte_pkg::CH_GT) &&
                    (o_data.out_char != xte_pkg::CH_QUOT) &&
                    (o_data.out_char != xte_pkg::CH_APOS))
        else $error("unescaped markup character on output");

    // Reset leaves no output beat pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind xml_text_escaper_core xte_checker u_xte_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
